### rtl/ohp_pkg.sv
// ----------------------------------------------------------------------------
// ohp_pkg: types and constants for the output hold with persistence block
// Shared item, result, state and configuration types, plus register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ohp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_DELTA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_DELTA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_PERSIST = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_PERSIST = 2'd3;

	// Direction of the last change relative to the base level
	localparam logic [1:0] DIR_EQUAL = 2'd0;
	localparam logic [1:0] DIR_BELOW = 2'd1;
	localparam logic [1:0] DIR_ABOVE = 2'd2;

	// Base levels above this mean "not yet captured"
	localparam logic [15:0] UNCAPTURED_LIMIT = 16'd101;
	localparam logic [15:0] BASE_RESET       = 16'hFFFF;
	localparam logic [6:0]  COUNT_MAX        = 7'd127;

	// Reset values of the configuration registers
	localparam logic [7:0] SMALL_DELTA_RST   = 8'd1;
	localparam logic [7:0] LARGE_DELTA_RST   = 8'd5;
	localparam logic [6:0] SMALL_PERSIST_RST = 7'd50;
	localparam logic [6:0] LARGE_PERSIST_RST = 7'd60;

	typedef struct packed {
		logic [15:0] level;
		logic [15:0] proposed_code;
	} samp_t;

	typedef struct packed {
		logic [15:0] out_code;
		logic        relatched;
	} res_t;

	typedef struct packed {
		logic [15:0] base_level;
		logic [15:0] held_code;
		logic [1:0]  last_dir;
		logic [6:0]  large_count;
		logic [6:0]  small_count;
	} hold_state_t;

	typedef struct packed {
		logic [7:0] small_delta;
		logic [7:0] large_delta;
		logic [6:0] small_persist;
		logic [6:0] large_persist;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/ohp_step.sv
// ----------------------------------------------------------------------------
// ohp_step: next-state and result logic for one item
// Capture, equal-level clear, direction change and persistence counting.
// ----------------------------------------------------------------------------
`default_nettype none

module ohp_step (
	input  ohp_pkg::hold_state_t st,
	input  ohp_pkg::cfg_t        cfg,
	input  ohp_pkg::samp_t       samp,
	output ohp_pkg::hold_state_t st_nxt,
	output ohp_pkg::res_t        res
);
	import ohp_pkg::*;

	// Saturating advance, or clear when the distance is not over threshold
	function automatic logic [6:0] bump(input logic [6:0] cnt, input logic over);
		logic [6:0] r;
		if (!over)
			r = '0;
		else if (cnt == COUNT_MAX)
			r = COUNT_MAX;
		else
			r = cnt + 7'd1;
		return r;
	endfunction

	logic        below;
	logic [1:0]  dir;
	logic [15:0] delta;
	logic [6:0]  small_b;
	logic [6:0]  large_b;

	// Direction and distance from the base level
	assign below = st.base_level > samp.level;
	assign dir   = below ? DIR_BELOW : DIR_ABOVE;
	assign delta = below ? (st.base_level - samp.level) : (samp.level - st.base_level);

	assign small_b = bump(st.small_count, delta > {8'd0, cfg.small_delta});
	assign large_b = bump(st.large_count, delta > {8'd0, cfg.large_delta});

	always_comb begin
		st_nxt        = st;
		res.out_code  = st.held_code;
		res.relatched = 1'b0;
		if (st.base_level > UNCAPTURED_LIMIT) begin
			// First capture (repeats while the captured level is out of range)
			st_nxt.base_level  = samp.level;
			st_nxt.held_code   = samp.proposed_code;
			st_nxt.last_dir    = DIR_EQUAL;
			st_nxt.large_count = '0;
			st_nxt.small_count = '0;
			res.out_code       = samp.proposed_code;
			res.relatched      = 1'b1;
		end else if (st.base_level == samp.level) begin
			st_nxt.last_dir    = DIR_EQUAL;
			st_nxt.large_count = '0;
			st_nxt.small_count = '0;
		end else if (dir != st.last_dir) begin
			// Turned round: restart persistence
			st_nxt.last_dir    = dir;
			st_nxt.large_count = '0;
			st_nxt.small_count = '0;
		end else begin
			st_nxt.large_count = large_b;
			st_nxt.small_count = small_b;
			if ((small_b > cfg.small_persist) || (large_b > cfg.large_persist)) begin
				st_nxt.base_level  = samp.level;
				st_nxt.held_code   = samp.proposed_code;
				st_nxt.large_count = '0;
				st_nxt.small_count = '0;
				res.out_code       = samp.proposed_code;
				res.relatched      = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/output_hold_with_persistence.sv
// ----------------------------------------------------------------------------
// output_hold_with_persistence: converter code hold with persistence filter
// Input register, combinational step logic, result register with state update.
// ----------------------------------------------------------------------------
// One item is accepted every cycle while samp_stall is low. The item is first
// held in the input register; when the result register can advance, the step
// logic updates the hold state and the result register at the same edge, so
// consecutive items see each other's state with no gap. samp_stall rises only
// when both the input register and the result register are full and res_stall
// is high. The configuration port is always ready; write it only while the
// block is idle.
`default_nettype none

module output_hold_with_persistence (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              samp_valid,
	output logic                             samp_stall,
	input  ohp_pkg::samp_t                   samp,
	output logic                             res_valid,
	input  wire                              res_stall,
	output ohp_pkg::res_t                    res,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [ohp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [7:0]                        cfg_data
);
	import ohp_pkg::*;

	samp_t       samp_s1;
	logic        samp_v_s1;
	res_t        res_q;
	logic        res_valid_q;
	hold_state_t st_q;
	hold_state_t st_nxt;
	res_t        res_nxt;
	cfg_t        cfg_q;
	logic        advance;

	assign advance    = !res_valid_q || !res_stall;
	assign samp_stall = samp_v_s1 && !advance;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign cfg_ready  = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.small_delta   <= SMALL_DELTA_RST;
			cfg_q.large_delta   <= LARGE_DELTA_RST;
			cfg_q.small_persist <= SMALL_PERSIST_RST;
			cfg_q.large_persist <= LARGE_PERSIST_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SMALL_DELTA:   cfg_q.small_delta   <= cfg_data;
				REG_LARGE_DELTA:   cfg_q.large_delta   <= cfg_data;
				REG_SMALL_PERSIST: cfg_q.small_persist <= cfg_data[6:0];
				REG_LARGE_PERSIST: cfg_q.large_persist <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_v_s1 <= 1'b0;
		end else if (!samp_stall) begin
			samp_v_s1 <= samp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samp_valid && !samp_stall) begin
			samp_s1 <= samp;
		end
	end

	ohp_step u_step (
		.st     (st_q),
		.cfg    (cfg_q),
		.samp   (samp_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q      <= 1'b0;
			st_q.base_level  <= BASE_RESET;
			st_q.held_code   <= '0;
			st_q.last_dir    <= DIR_EQUAL;
			st_q.large_count <= '0;
			st_q.small_count <= '0;
		end else if (advance) begin
			res_valid_q <= samp_v_s1;
			if (samp_v_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && samp_v_s1) begin
			res_q <= res_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/ohp_checker.sv
// ----------------------------------------------------------------------------
// ohp_checker: port-level checks for output_hold_with_persistence
// Watches the result stream for hold consistency and the stall back-path.
// ----------------------------------------------------------------------------
`default_nettype none

module ohp_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  samp_stall,
	input wire                  res_valid,
	input wire                  res_stall,
	input ohp_pkg::res_t        res
);
	import ohp_pkg::*;

	logic        have_prev_q;
	logic [15:0] prev_code_q;

	// Last delivered code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_code_q <= '0;
		end else if (res_valid && !res_stall) begin
			have_prev_q <= 1'b1;
			prev_code_q <= res.out_code;
		end
	end

	// The first result after reset always captures
	a_first_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !have_prev_q) |-> res.relatched)
		else $error("first result after reset not relatched");

	// Without a re-latch the code repeats the previous item's code
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && have_prev_q && !res.relatched) |-> (res.out_code == prev_code_q))
		else $error("held code changed without re-latch");

	// Input stalls only when the output side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		samp_stall |-> (res_valid && res_stall))
		else $error("input stalled with output free");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("stalled result changed");

endmodule

bind output_hold_with_persistence ohp_checker u_ohp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.samp_stall (samp_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

`default_nettype wire
